// File: rtl/fmv_pkg.sv
// Shared types, constants and elaboration-time functions of the FM operator voice.
// Used by fmv_dp, fmv_ctrl and fm_operator_adsr_voice; depends on nothing.
package fmv_pkg;

  // Default geometry
  localparam int PHASE_BITS_DEF      = 24;
  localparam int SINE_TABLE_BITS_DEF = 10;

  // Field widths
  localparam int IN_W       = 24;
  localparam int LEVEL_W    = 16;
  localparam int ENV_W      = 17;
  localparam int COEF_W     = 18;
  localparam int FS_W       = 18;
  localparam int SAMPLE_W   = 16;
  localparam int STAGE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Divider geometry
  localparam int DIV_DW = 32;
  localparam int DIV_VW = 18;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_TIME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_PEAK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = 3'd5;

  // Envelope stage codes (also the coefficient slot of each stage)
  localparam logic [STAGE_W-1:0] ST_RELEASE = 2'd0;
  localparam logic [STAGE_W-1:0] ST_ATTACK  = 2'd1;
  localparam logic [STAGE_W-1:0] ST_DECAY   = 2'd2;

  // Multiplier operand selection
  localparam logic [2:0] MUL_FLN  = 3'd0;  // frac * ln2
  localparam logic [2:0] MUL_YT   = 3'd1;  // Horner term y * t
  localparam logic [2:0] MUL_AT   = 3'd2;  // scale * 2^frac
  localparam logic [2:0] MUL_STEP = 3'd3;  // envelope distance * coefficient
  localparam logic [2:0] MUL_AMP  = 3'd4;  // sine magnitude * envelope

  // Fixed-point constants
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;
  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [63:0] PI_HALF    = 64'd1686629713;
  localparam logic [31:0] LN2_Q30    = 32'd744261118;
  localparam logic [63:0] A_FULL     = PI_Q30 * 64'd256000;
  localparam logic [31:0] A_COEF     = A_FULL[51:20];
  localparam logic [ENV_W-1:0]  ENV_PEAK    = 17'd72090;
  localparam logic [ENV_W-1:0]  SUSTAIN_MAX = 17'd65536;
  localparam logic [ENV_W-1:0]  NEAR_LIMIT  = 17'd65;
  localparam logic [COEF_W-1:0] FC_ONE      = 18'd131072;

  // Command and status between controller and datapath
  typedef struct packed {
    logic       coef_first;
    logic       coef_setup;
    logic       y_load;
    logic       div_k;
    logic       t_update;
    logic       div_fs;
    logic       coef_store;
    logic       item_load;
    logic       env_update;
    logic       out_load;
    logic [2:0] mul_sel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic k_last;
    logic cs_last;
  } stat_t;

  // Quarter-wave sine magnitude, Q1.16, for point j of 2^k per quarter turn
  function automatic logic [ENV_W-1:0] sine_mag(input int k, input int j);
    longint unsigned u;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned m;
    u = longint'(j) << (30 - k);
    x = (u * PI_HALF) >> 30;
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    t = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
    t = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s = (x * t) >> 30;
    if (s > ONE_Q30) s = ONE_Q30;
    m = (s + 64'd8192) >> 14;
    return m[ENV_W-1:0];
  endfunction

endpackage

// File: rtl/fmv_div.sv
// Restoring divider, one quotient bit per cycle, shared by the coefficient sequence.
// Depends on nothing beyond its parameters.
module fmv_div #(
  parameter int DW = 32,
  parameter int VW = 18
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] LAST = CW'(DW - 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          fits;

  // Trial subtraction of the shifted remainder
  always_comb begin
    rem_sh  = {rem, quo[DW-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    fits    = rem_sh >= {1'b0, dvs};
  end

  // Count iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift in one quotient bit
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient = quo;
endmodule

// File: rtl/fmv_dp.sv
// Datapath of the FM operator voice: registers, phase, envelope, sine ROM, shared multiplier.
// Depends on fmv_pkg and fmv_div.
module fmv_dp #(
  parameter int PHASE_BITS      = fmv_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = fmv_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  fmv_pkg::cmd_t                          cmd,
  output fmv_pkg::stat_t                         stat,
  input  logic                                   cfg_write,
  input  logic [fmv_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [fmv_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                   gate,
  input  logic [fmv_pkg::IN_W-1:0]               phase_increment,
  input  logic signed [fmv_pkg::IN_W-1:0]        phase_offset,
  output logic signed [fmv_pkg::SAMPLE_W-1:0]    sample,
  output logic [fmv_pkg::ENV_W-1:0]              envelope,
  output logic [fmv_pkg::STAGE_W-1:0]            stage
);
  import fmv_pkg::*;

  localparam int PB   = PHASE_BITS;
  localparam int STB  = SINE_TABLE_BITS;
  localparam int K    = STB - 2;
  localparam int NS   = 1 << K;
  localparam int SH_L = (PB >= IN_W) ? PB - IN_W : 0;
  localparam int SH_R = (PB >= IN_W) ? 0 : IN_W - PB;
  localparam logic [ENV_W-1:0] SINE_TOP = sine_mag(K, NS);

  // Configuration registers
  logic [LEVEL_W-1:0] attack_time;
  logic [LEVEL_W-1:0] decay_time;
  logic [LEVEL_W-1:0] release_time;
  logic [ENV_W-1:0]   attack_peak;
  logic [ENV_W-1:0]   sustain;
  logic [FS_W-1:0]    sample_rate;

  // Voice state
  logic [PB-1:0]      phase_acc;
  logic [ENV_W-1:0]   env;
  logic [STAGE_W-1:0] env_stage;
  logic [COEF_W-1:0]  coef [3];

  // Coefficient sequence registers
  logic [1:0]  cs;
  logic [4:0]  np;
  logic [29:0] y;
  logic [31:0] t;
  logic [2:0]  k;

  // Item registers
  logic [STAGE_W-1:0] stage_new;
  logic [ENV_W-1:0]   tdiff;
  logic               up;
  logic [COEF_W-1:0]  fc;
  logic [ENV_W-1:0]   mag;
  logic               neg;
  logic [63:0]        prod;

  // Output registers
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [ENV_W-1:0]           envelope_r;
  logic [STAGE_W-1:0]         stage_r;

  // Divider hookup
  logic              div_start;
  logic [DIV_DW-1:0] div_num;
  logic [DIV_VW-1:0] div_den;
  logic [DIV_DW-1:0] div_q;
  logic              div_done;

  // Combinational helpers
  logic [LEVEL_W-1:0]     lv_raw;
  logic signed [19:0]     lv_c;
  logic signed [19:0]     g;
  logic [13:0]            ff;
  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic [31:0]            b_val;
  logic [4:0]             nsh;
  logic [FS_W-1:0]        fs_eff;
  logic [55:0]            inc_w;
  logic [55:0]            off_w;
  logic [PB-1:0]          phase_sum;
  logic [ENV_W-1:0]       peak;
  logic [ENV_W-1:0]       sus;
  logic [ENV_W-1:0]       dpeak;
  logic                   near;
  logic [ENV_W-1:0]       target;
  logic [COEF_W-1:0]      fc_sel;
  logic [STAGE_W-1:0]     stage_sel;
  logic [ENV_W-1:0]       step;
  logic [STB-1:0]         idx;
  logic [K-1:0]           frac;
  logic [K-1:0]           frac_neg;
  logic [ENV_W-1:0]       mag_sel;
  logic [15:0]            amp;
  logic [SAMPLE_W-1:0]    amp_sat;
  logic [ENV_W-1:0]       sine_rom [NS];

  // Quarter-wave ROM, built at elaboration
  for (genvar gi = 0; gi < NS; gi++) begin : g_rom
    localparam logic [ENV_W-1:0] V = sine_mag(K, gi);
    assign sine_rom[gi] = V;
  end

  // Level of the coefficient slot in work, clamped, split into exponent parts
  always_comb begin
    case (cs)
      ST_RELEASE: lv_raw = release_time;
      ST_ATTACK:  lv_raw = attack_time;
      default:    lv_raw = decay_time;
    endcase
    lv_c = {{4{lv_raw[LEVEL_W-1]}}, lv_raw};
    if (lv_c > 20'sd16384) lv_c = 20'sd16384;
    if (lv_c < -20'sd16384) lv_c = -20'sd16384;
    g  = 20'sd163840 - lv_c * 20'sd10;
    ff = g[13:0];
  end

  // Shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MUL_FLN: begin
        mul_a = {18'b0, ff};
        mul_b = LN2_Q30;
      end
      MUL_YT: begin
        mul_a = {2'b0, y};
        mul_b = t;
      end
      MUL_AT: begin
        mul_a = A_COEF;
        mul_b = t;
      end
      MUL_STEP: begin
        mul_a = {15'b0, tdiff};
        mul_b = {14'b0, fc};
      end
      MUL_AMP: begin
        mul_a = {15'b0, mag};
        mul_b = {15'b0, env};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Divider operands: Horner term over k, or scaled numerator over the sample rate
  always_comb begin
    b_val     = prod[61:30];
    nsh       = 5'd20 - np;
    fs_eff    = (sample_rate == '0) ? FS_W'(1) : sample_rate;
    div_start = cmd.div_k | cmd.div_fs;
    if (cmd.div_fs) begin
      div_num = b_val >> nsh;
      div_den = fs_eff;
    end else begin
      div_num = prod[61:30];
      div_den = {15'b0, k};
    end
  end

  fmv_div #(
    .DW(DIV_DW),
    .VW(DIV_VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_q),
    .done     (div_done)
  );

  assign stat.div_done = div_done;
  assign stat.k_last   = (k == 3'd1);
  assign stat.cs_last  = (cs == ST_DECAY);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_time  <= '0;
      decay_time   <= '0;
      release_time <= '0;
      attack_peak  <= 17'd65536;
      sustain      <= 17'd32768;
      sample_rate  <= 18'd48000;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ATTACK_TIME:  attack_time  <= cfg_data[LEVEL_W-1:0];
        REG_DECAY_TIME:   decay_time   <= cfg_data[LEVEL_W-1:0];
        REG_RELEASE_TIME: release_time <= cfg_data[LEVEL_W-1:0];
        REG_ATTACK_PEAK:  attack_peak  <= cfg_data[ENV_W-1:0];
        REG_SUSTAIN:      sustain      <= cfg_data[ENV_W-1:0];
        REG_SAMPLE_RATE:  sample_rate  <= cfg_data[FS_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient slot pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      cs <= '0;
    end else if (cmd.coef_first) begin
      cs <= '0;
    end else if (cmd.coef_store) begin
      cs <= cs + 1'b1;
    end
  end

  // Exponential and coefficient registers
  always_ff @(posedge clk) begin
    if (cmd.coef_setup) np <= g[18:14];
    if (cmd.y_load) begin
      y <= prod[43:14];
      t <= ONE_Q30[31:0];
      k <= 3'd7;
    end else if (cmd.t_update) begin
      t <= ONE_Q30[31:0] + div_q;
      k <= k - 1'b1;
    end
    if (cmd.coef_store) begin
      coef[cs] <= (div_q > {14'b0, FC_ONE}) ? FC_ONE : div_q[COEF_W-1:0];
    end
  end

  // Phase step and stage choice for a new item
  always_comb begin
    inc_w     = ({32'b0, phase_increment} << SH_L) >> SH_R;
    off_w     = ({32'b0, phase_offset} << SH_L) >> SH_R;
    phase_sum = phase_acc + inc_w[PB-1:0] + off_w[PB-1:0];
    peak      = (attack_peak > ENV_PEAK) ? ENV_PEAK : attack_peak;
    sus       = (sustain > SUSTAIN_MAX) ? SUSTAIN_MAX : sustain;
    dpeak     = (env > peak) ? env - peak : peak - env;
    near      = dpeak <= NEAR_LIMIT;
    case (env_stage)
      ST_ATTACK: begin
        stage_sel = near ? ST_DECAY : (gate ? ST_ATTACK : ST_RELEASE);
        target    = ENV_PEAK;
        fc_sel    = coef[ST_ATTACK];
      end
      ST_DECAY: begin
        stage_sel = gate ? ST_DECAY : ST_RELEASE;
        target    = sus;
        fc_sel    = coef[ST_DECAY];
      end
      default: begin
        stage_sel = gate ? ST_ATTACK : env_stage;
        target    = '0;
        fc_sel    = coef[ST_RELEASE];
      end
    endcase
  end

  // Voice state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      env       <= '0;
      env_stage <= ST_RELEASE;
    end else begin
      if (cmd.item_load) phase_acc <= phase_sum;
      if (cmd.env_update) begin
        env       <= up ? env + step : env - step;
        env_stage <= stage_new;
      end
    end
  end

  // Hold item values
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      stage_new <= stage_sel;
      tdiff     <= (target > env) ? target - env : env - target;
      up        <= target > env;
      fc        <= fc_sel;
    end
  end

  // Filter step, at least one LSB while moving
  always_comb begin
    step = prod[33:17];
    if (step == '0 && fc != '0 && tdiff != '0) step = ENV_W'(1);
  end

  // Sine lookup with quadrant symmetry
  always_comb begin
    idx      = phase_acc[PB-1 -: STB];
    frac     = idx[K-1:0];
    frac_neg = ~frac + 1'b1;
    if (!idx[STB-2]) begin
      mag_sel = sine_rom[frac];
    end else if (frac == '0) begin
      mag_sel = SINE_TOP;
    end else begin
      mag_sel = sine_rom[frac_neg];
    end
  end

  always_ff @(posedge clk) begin
    mag <= mag_sel;
    neg <= idx[STB-1];
  end

  // Scale, saturate and sign the sample
  always_comb begin
    amp     = prod[33:18];
    amp_sat = amp[15] ? 16'h7FFF : amp;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_r   <= neg ? -$signed(amp_sat) : $signed(amp_sat);
      envelope_r <= env;
      stage_r    <= env_stage;
    end
  end

  assign sample   = sample_r;
  assign envelope = envelope_r;
  assign stage    = stage_r;
endmodule

// File: rtl/fmv_ctrl.sv
// Controller of the FM operator voice: sequences coefficient builds and sample items.
// Depends on fmv_pkg.
module fmv_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  fmv_pkg::stat_t stat,
  output fmv_pkg::cmd_t  cmd
);
  import fmv_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EMUL  = 4'd1;
  localparam logic [3:0] S_EUPD  = 4'd2;
  localparam logic [3:0] S_SMUL  = 4'd3;
  localparam logic [3:0] S_OUT   = 4'd4;
  localparam logic [3:0] C_SETUP = 4'd5;
  localparam logic [3:0] C_YLD   = 4'd6;
  localparam logic [3:0] C_MULT  = 4'd7;
  localparam logic [3:0] C_DIVK  = 4'd8;
  localparam logic [3:0] C_WAITK = 4'd9;
  localparam logic [3:0] C_MULA  = 4'd10;
  localparam logic [3:0] C_DIVF  = 4'd11;
  localparam logic [3:0] C_WAITF = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE) && !cfg_write;
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.item_load = 1'b1;
          state_next    = S_EMUL;
        end
      end
      S_EMUL: begin
        cmd.mul_sel = MUL_STEP;
        state_next  = S_EUPD;
      end
      S_EUPD: begin
        cmd.env_update = 1'b1;
        state_next     = S_SMUL;
      end
      S_SMUL: begin
        cmd.mul_sel = MUL_AMP;
        state_next  = S_OUT;
      end
      S_OUT: begin
        // keep the amplitude product in place while the result waits
        cmd.mul_sel = MUL_AMP;
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      C_SETUP: begin
        cmd.coef_setup = 1'b1;
        cmd.mul_sel    = MUL_FLN;
        state_next     = C_YLD;
      end
      C_YLD: begin
        cmd.y_load = 1'b1;
        state_next = C_MULT;
      end
      C_MULT: begin
        cmd.mul_sel = MUL_YT;
        state_next  = C_DIVK;
      end
      C_DIVK: begin
        cmd.div_k  = 1'b1;
        state_next = C_WAITK;
      end
      C_WAITK: begin
        if (stat.div_done) begin
          cmd.t_update = 1'b1;
          state_next   = stat.k_last ? C_MULA : C_MULT;
        end
      end
      C_MULA: begin
        cmd.mul_sel = MUL_AT;
        state_next  = C_DIVF;
      end
      C_DIVF: begin
        cmd.div_fs = 1'b1;
        state_next = C_WAITF;
      end
      C_WAITF: begin
        if (stat.div_done) begin
          cmd.coef_store = 1'b1;
          state_next     = stat.cs_last ? S_IDLE : C_SETUP;
        end
      end
      default: state_next = C_SETUP;
    endcase
    // Restart the coefficient build on any register write
    if (cfg_write) begin
      cmd            = '0;
      cmd.coef_first = 1'b1;
      state_next     = C_SETUP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_SETUP;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// File: rtl/fm_operator_adsr_voice.sv
// Top level of the FM operator voice: sine oscillator scaled by a three-stage envelope.
// Depends on fmv_pkg, fmv_ctrl and fmv_dp.
//
//   channel | signals                                         | handshake
//   --------+-------------------------------------------------+----------------------
//   in      | gate, phase_increment, phase_offset             | in_valid / in_ready
//   out     | sample, envelope, stage                         | out_valid / out_ready
//   cfg     | cfg_index, cfg_data                             | cfg_write, no wait
//
// An item's result register loads after the states S_EMUL, S_EUPD, S_SMUL and S_OUT, and
// a new item is taken only once the last is through, as the single shared multiplier is
// used twice per item. After reset and after every register write the three filter
// coefficients are rebuilt through the shared multiplier and a bit-serial divider, and
// no item is taken meanwhile. A result waiting on out_ready holds; the next item may run
// and stalls only before its own result is loaded.
module fm_operator_adsr_voice #(
  parameter int PHASE_BITS      = fmv_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = fmv_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                gate,
  input  logic [fmv_pkg::IN_W-1:0]            phase_increment,
  input  logic signed [fmv_pkg::IN_W-1:0]     phase_offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fmv_pkg::SAMPLE_W-1:0] sample,
  output logic [fmv_pkg::ENV_W-1:0]           envelope,
  output logic [fmv_pkg::STAGE_W-1:0]         stage,
  input  logic                                cfg_write,
  input  logic [fmv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fmv_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fmv_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fmv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fmv_dp #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .gate            (gate),
    .phase_increment (phase_increment),
    .phase_offset    (phase_offset),
    .sample          (sample),
    .envelope        (envelope),
    .stage           (stage)
  );
endmodule

// File: dv/tb_fm_operator_adsr_voice.sv
`timescale 1ns / 1ps
// Self-checking testbench of the FM operator voice: sine oscillator times ADSR envelope.
// Depends on fmv_pkg and fm_operator_adsr_voice; predicts every sample bit for bit.
module tb_fm_operator_adsr_voice;
  import fmv_pkg::*;

  typedef struct {
    logic                 gate;
    logic [IN_W-1:0]      inc;
    logic [IN_W-1:0]      ofs;
  } voice_item_t;

  typedef struct {
    logic [SAMPLE_W-1:0]  smp;
    logic [ENV_W-1:0]     env;
    logic [STAGE_W-1:0]   stg;
  } voice_out_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       gate = 1'b0;
  logic [IN_W-1:0]            phase_increment = '0;
  logic signed [IN_W-1:0]     phase_offset = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic [ENV_W-1:0]           envelope;
  logic [STAGE_W-1:0]         stage;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  fm_operator_adsr_voice dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: registers, coefficients, phase and envelope
  logic [LEVEL_W-1:0]  lvl_attack, lvl_decay, lvl_release;
  logic [ENV_W-1:0]    peak_reg, sus_reg;
  logic [FS_W-1:0]     fs_reg;
  logic [COEF_W-1:0]   stage_coef [3];
  logic [23:0]         phase_q;
  logic [ENV_W-1:0]    env_q;
  logic [STAGE_W-1:0]  stage_q;

  voice_item_t pending_items[$];
  voice_out_t  expected_samples[$];
  int          fail_count = 0;
  int          samples_seen = 0;

  // 2^(f/16384) in Q2.30 by a seventh-order Taylor series
  function automatic longint unsigned exp2_frac(longint unsigned f);
    longint unsigned y, t;
    y = (f * 64'd744261118) >> 14;
    t = ONE_Q30;
    for (int k = 7; k >= 1; k--)
      t = ONE_Q30 + ((y * t) >> 30) / longint'(k);
    return t;
  endfunction

  // One-pole coefficient, Q1.17, for a time level and sample rate
  function automatic logic [COEF_W-1:0] level_to_coef(logic [LEVEL_W-1:0] raw,
                                                     logic [FS_W-1:0] rate);
    int lv;
    longint unsigned g, np, f, a, b, num, den, q, fs;
    lv = int'($signed(raw));
    if (lv > 16384) lv = 16384;
    if (lv < -16384) lv = -16384;
    g = longint'(163840 - 10 * lv);
    np = g >> 14;
    f = g & 64'd16383;
    a = (64'd3373259426 * 64'd256000) >> 20;
    b = (a * exp2_frac(f)) >> 30;
    fs = (rate == 0) ? 64'd1 : longint'(rate);
    if (np >= 10) begin
      num = b << (np - 10);
      den = fs << 10;
    end else begin
      num = b;
      den = fs << (20 - np);
    end
    q = num / den;
    return (q > 64'd131072) ? 18'd131072 : q[COEF_W-1:0];
  endfunction

  // Signed sine of the top ten phase bits, Q1.16
  function automatic int sine_of_phase(logic [23:0] ph);
    logic [9:0] idx;
    longint unsigned u, x, x2, t, s, m;
    int dens [6] = '{156, 110, 72, 42, 20, 6};
    idx = ph[23:14];
    u = longint'(idx[7:0]) << 22;
    if (idx[8]) u = ONE_Q30 - u;
    x = (u * (64'd3373259426 / 2)) >> 30;
    x2 = (x * x) >> 30;
    t = ONE_Q30;
    for (int i = 0; i < 6; i++)
      t = ONE_Q30 - ((x2 * t) >> 30) / longint'(dens[i]);
    s = (x * t) >> 30;
    if (s > ONE_Q30) s = ONE_Q30;
    m = (s + 64'd8192) >> 14;
    return idx[9] ? -int'(m) : int'(m);
  endfunction

  function automatic void rebuild_coefs();
    stage_coef[ST_RELEASE] = level_to_coef(lvl_release, fs_reg);
    stage_coef[ST_ATTACK]  = level_to_coef(lvl_attack, fs_reg);
    stage_coef[ST_DECAY]   = level_to_coef(lvl_decay, fs_reg);
  endfunction

  // Advance the voice by one sample tick and queue the expected result
  function automatic void advance_voice(voice_item_t it);
    logic [ENV_W-1:0]  peak, sus, target, span, step;
    logic [COEF_W-1:0] fc;
    longint unsigned   prod;
    int                sn, mag;
    voice_out_t        r;
    phase_q = phase_q + it.inc + it.ofs;
    peak = (peak_reg > ENV_PEAK) ? ENV_PEAK : peak_reg;
    sus = (sus_reg > SUSTAIN_MAX) ? SUSTAIN_MAX : sus_reg;
    case (stage_q)
      ST_ATTACK: begin
        span = (env_q > peak) ? env_q - peak : peak - env_q;
        target = ENV_PEAK;
        fc = stage_coef[ST_ATTACK];
        if (span <= NEAR_LIMIT) stage_q = ST_DECAY;
        else if (!it.gate) stage_q = ST_RELEASE;
      end
      ST_DECAY: begin
        target = sus;
        fc = stage_coef[ST_DECAY];
        if (!it.gate) stage_q = ST_RELEASE;
      end
      default: begin
        target = '0;
        fc = stage_coef[ST_RELEASE];
        if (it.gate) stage_q = ST_ATTACK;
      end
    endcase
    span = (target > env_q) ? target - env_q : env_q - target;
    prod = (longint'(span) * longint'(fc)) >> 17;
    step = prod[ENV_W-1:0];
    if (step == 0 && fc != 0 && span != 0) step = ENV_W'(1);
    env_q = (target > env_q) ? env_q + step : env_q - step;
    sn = sine_of_phase(phase_q);
    mag = (sn < 0) ? -sn : sn;
    prod = (longint'(mag) * longint'(env_q)) >> 18;
    if (prod > 32767) prod = 32767;
    r.smp = (sn < 0) ? -prod[15:0] : prod[15:0];
    r.env = env_q;
    r.stg = stage_q;
    expected_samples.push_back(r);
  endfunction

  // Driver: bursts of items separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    voice_item_t it;
    if (!rst) begin
      if (in_valid && in_ready)
        advance_voice('{gate, phase_increment, phase_offset});
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          gate <= it.gate;
          phase_increment <= it.inc;
          phase_offset <= it.ofs;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(40, 1);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each sample, stall on a shifting pattern, one long hold-off
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    voice_out_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        samples_seen <= samples_seen + 1;
        if (expected_samples.size() == 0) begin
          $display("%0t: expected no item, actual sample %0d env %0d stage %0d",
                   $time, sample, envelope, stage);
          fail_count++;
        end else begin
          e = expected_samples.pop_front();
          if (sample !== e.smp) begin
            $display("%0t: sample expected %0d actual %0d", $time, $signed(e.smp), sample);
            fail_count++;
          end
          if (envelope !== e.env) begin
            $display("%0t: envelope expected %0d actual %0d", $time, e.env, envelope);
            fail_count++;
          end
          if (stage !== e.stg) begin
            $display("%0t: stage expected %0d actual %0d", $time, e.stg, stage);
            fail_count++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(2, 0);
        mode_left <= $urandom_range(80, 10);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (!hold_done && samples_seen == 300) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(3, 0) != 0);
          default: out_ready <= ($urandom_range(3, 0) == 0);
        endcase
      end
    end
  end

  // Write one register and mirror it; unknown indexes are dropped
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    logic [31:0] v;
    v = val;
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ATTACK_TIME:  lvl_attack = v[15:0];
      REG_DECAY_TIME:   lvl_decay = v[15:0];
      REG_RELEASE_TIME: lvl_release = v[15:0];
      REG_ATTACK_PEAK:  peak_reg = v[16:0];
      REG_SUSTAIN:      sus_reg = v[16:0];
      REG_SAMPLE_RATE:  fs_reg = v[17:0];
      default: ;
    endcase
    rebuild_coefs();
    // hold until the coefficient rebuild lets items in again
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_all(int att, int dec, int rel, int pk, int sus, int fs);
    write_reg(REG_ATTACK_TIME, att);
    write_reg(REG_DECAY_TIME, dec);
    write_reg(REG_RELEASE_TIME, rel);
    write_reg(REG_ATTACK_PEAK, pk);
    write_reg(REG_SUSTAIN, sus);
    write_reg(REG_SAMPLE_RATE, fs);
  endtask

  task automatic push_item(logic g, logic [IN_W-1:0] inc, logic [IN_W-1:0] ofs);
    pending_items.push_back('{g, inc, ofs});
  endtask

  // Mostly key-on/key-off runs with random pitch, some gate noise
  task automatic push_random(int count);
    int n;
    int run;
    logic g;
    logic [IN_W-1:0] inc, ofs;
    n = 0;
    while (n < count) begin
      g = 1'b1;
      if ($urandom_range(5, 0) == 0) run = $urandom_range(4, 1);
      else run = $urandom_range(60, 1);
      for (int i = 0; i < run; i++) begin
        inc = ($urandom_range(1, 0) != 0) ? IN_W'($urandom_range(200000, 0))
                                          : IN_W'($urandom);
        case ($urandom_range(3, 0))
          0: ofs = IN_W'($urandom);
          1: ofs = IN_W'($urandom_range(4000, 0) - 2000);
          default: ofs = '0;
        endcase
        push_item($urandom_range(9, 0) == 0 ? ~g : g, inc, ofs);
        n++;
      end
      g = 1'b0;
      run = $urandom_range(30, 1);
      for (int i = 0; i < run; i++) begin
        push_item(g, IN_W'($urandom), ($urandom_range(1, 0) != 0) ? IN_W'($urandom) : '0);
        n++;
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Stimulus sequence
  initial begin
    lvl_attack = '0;
    lvl_decay = '0;
    lvl_release = '0;
    peak_reg = 17'd65536;
    sus_reg = 17'd32768;
    fs_reg = 18'd48000;
    rebuild_coefs();
    phase_q = '0;
    env_q = '0;
    stage_q = ST_RELEASE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    // Directed: field extremes and the attack and release transitions at reset settings
    push_item(1'b0, '0, '0);
    push_item(1'b0, 24'hFFFFFF, '0);
    push_item(1'b0, '0, 24'h7FFFFF);
    push_item(1'b0, '0, 24'h800000);
    push_item(1'b0, '0, 24'hFFFFFF);
    for (int i = 0; i < 10; i++) push_item(1'b1, 24'h040000, '0);
    push_item(1'b1, 24'h400000, 24'h000001);
    push_item(1'b0, 24'h400000, '0);
    push_item(1'b1, 24'h555555, 24'hAAAAAA);
    for (int i = 0; i < 4; i++) push_item(1'b0, 24'h100000, '0);
    drain();

    // Fast stages so decay and sustain get reached
    write_all(-16384, -8000, -12000, 65536, 32768, 48000);
    push_random(220);
    drain();

    // Out-of-range levels, peak and sustain saturate, rate zero, unknown index
    write_all(32767, -32768, -16384, 131071, 131071, 0);
    write_reg(3'd6, 12345);
    write_reg(3'd7, 262143);
    push_random(200);
    drain();

    // Highest rate, zero peak and sustain
    write_all(-5000, 16384, 5000, 0, 0, 262143);
    push_random(200);
    drain();

    write_all(3000, -3000, 100, 72090, 65536, 8000);
    push_random(220);
    drain();

    write_all(-16384, -16384, -16384, 70000, 1000, 192000);
    push_random(220);
    drain();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
